// ===== rtl/skpn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skpn_pkg: shared types and codes of the sorted key/page node
// Field widths, request kinds, status codes and the per-cell command set.
// ----------------------------------------------------------------------------
package skpn_pkg;

	// fixed field widths of the channels
	localparam int KIND_W    = 3;
	localparam int KEY_IN_W  = 32;
	localparam int PAGE_W    = 31;
	localparam int STAT_W    = 2;
	localparam int CNT_OUT_W = 5;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FLOOR  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EXACT  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd4;
	localparam logic [KIND_W-1:0] KIND_REKEY  = 3'd5;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DUP    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd3;

	// register indexes (word index in the register map)
	localparam logic REG_KEY_SIGNED = 1'b0;

	// what one cell does at the end of the apply cycle
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_SHIFT_UP,
		CELL_SHIFT_DOWN,
		CELL_SET_PAGE,
		CELL_SET_KEY
	} cell_op_t;

	// registered compare results of one occupied cell
	typedef struct packed {
		logic eq_key;
		logic ge_key;
		logic eq_page;
	} cell_flags_t;

endpackage

`default_nettype wire

// ===== rtl/skpn_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skpn_req_if: request channel
// valid/ready channel carrying one node request.
// ----------------------------------------------------------------------------
interface skpn_req_if;
	import skpn_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [KEY_IN_W-1:0] key;
	logic [PAGE_W-1:0]   page;

	modport source (output valid, kind, key, page, input ready);
	modport sink (input valid, kind, key, page, output ready);

endinterface

`default_nettype wire

// ===== rtl/skpn_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skpn_rsp_if: response channel
// valid/ready channel carrying one node response.
// ----------------------------------------------------------------------------
interface skpn_rsp_if;
	import skpn_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 found;
	logic [PAGE_W-1:0]    page_out;
	logic [STAT_W-1:0]    status;
	logic [CNT_OUT_W-1:0] entry_count;

	modport source (output valid, found, page_out, status, entry_count, input ready);
	modport sink (input valid, found, page_out, status, entry_count, output ready);

endinterface

`default_nettype wire

// ===== rtl/skpn_prefix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skpn_prefix: inclusive prefix OR across the cell row
// Log-depth (Kogge-Stone) network; bit i is the OR of bits 0..i.
// ----------------------------------------------------------------------------
module skpn_prefix #(
	parameter int N = 16
) (
	input  wire logic [N-1:0] a,
	output logic      [N-1:0] incl
);
	localparam int LVL = $clog2(N);

	logic [N-1:0] stage [LVL+1];

	assign stage[0] = a;

	// each level doubles the span covered
	for (genvar l = 0; l < LVL; l++) begin : g_lvl
		for (genvar i = 0; i < N; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_or
				assign stage[l+1][i] = stage[l][i] | stage[l][i-(1<<l)];
			end else begin : g_pass
				assign stage[l+1][i] = stage[l][i];
			end
		end
	end

	assign incl = stage[LVL];

endmodule

`default_nettype wire

// ===== rtl/skpn_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skpn_cell: one key/page slot of the node row
// Compares its pair against the pending request, registers the flags, and
// loads, shifts from a neighbor or rewrites a field on command.
// ----------------------------------------------------------------------------
module skpn_cell #(
	parameter int KW = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cap_en,
	input  wire logic                          occ,
	input  wire logic                          key_signed,
	input  wire logic [KW-1:0]                 cmp_key,
	input  wire logic [skpn_pkg::PAGE_W-1:0]   cmp_page,
	input  wire skpn_pkg::cell_op_t            op,
	input  wire logic [KW-1:0]                 lo_key,
	input  wire logic [skpn_pkg::PAGE_W-1:0]   lo_page,
	input  wire logic [KW-1:0]                 hi_key,
	input  wire logic [skpn_pkg::PAGE_W-1:0]   hi_page,
	output logic      [KW-1:0]                 key,
	output logic      [skpn_pkg::PAGE_W-1:0]   page,
	output skpn_pkg::cell_flags_t              flags
);
	import skpn_pkg::*;

	logic [KW-1:0]     key_q;
	logic [PAGE_W-1:0] page_q;
	cell_flags_t       flags_q;
	logic [KW-1:0]     top_bit;
	logic              above;

	// signed order: flip the sign bit and compare unsigned
	assign top_bit = {key_signed, {(KW-1){1'b0}}};
	assign above   = (cmp_key ^ top_bit) > (key_q ^ top_bit);

	// compare flags, taken in the compare cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (cap_en) begin
			flags_q.eq_key  <= occ && (cmp_key == key_q);
			flags_q.ge_key  <= occ && !above;
			flags_q.eq_page <= occ && (cmp_page == page_q);
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD: begin
				key_q  <= cmp_key;
				page_q <= cmp_page;
			end
			CELL_SHIFT_UP: begin
				key_q  <= lo_key;
				page_q <= lo_page;
			end
			CELL_SHIFT_DOWN: begin
				key_q  <= hi_key;
				page_q <= hi_page;
			end
			CELL_SET_PAGE: begin
				page_q <= cmp_page;
			end
			CELL_SET_KEY: begin
				key_q <= cmp_key;
			end
			default: begin
			end
		endcase
	end

	assign key   = key_q;
	assign page  = page_q;
	assign flags = flags_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_key_pointer_node_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_pointer_node_top: one B+ tree node as a row of key/page cells
// Keeps up to ENTRIES pairs in key order; insert, remove, floor and exact
// search, page update and rekey, one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   req (valid/ready): kind, key, page. rsp (valid/ready): found, page_out,
//   status, entry_count. One rsp transfer for every req transfer, in order.
//   APB port: word 0 bit 0 is key_signed (reset 1); write it only while the
//   node is idle.
// Timing:
//   A request is taken, all cells compare against it in the next cycle and
//   register their flags; once no response is left pending, the row shifts
//   or rewrites and the response register loads. The next request is taken
//   in that same apply cycle. Each request passes through the cell compare
//   stage and then the prefix/apply stage.
// Reset:
//   arst_n clears the entry count, the response valid flag, the cell flags and the sequencer;
//   the node starts empty. Slot contents are not cleared.
// Stall:
//   While rsp.ready is low with a response pending, the next request waits
//   in the apply cycle and req.ready stays low; nothing is lost.
// ----------------------------------------------------------------------------
module sorted_key_pointer_node_top #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	skpn_req_if.sink                             req,
	skpn_rsp_if.source                           rsp,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [skpn_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [skpn_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [skpn_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready
);
	import skpn_pkg::*;

	localparam int CW = $clog2(ENTRIES + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CMP   = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;

	logic [1:0]          state_q;
	logic                key_signed_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       cnt_next;
	logic [KIND_W-1:0]   kind_q;
	logic [KEY_BITS-1:0] key_q;
	logic [PAGE_W-1:0]   page_q;
	logic [KEY_BITS-1:0] key_ext;

	logic                 out_valid_q;
	logic                 found_q;
	logic [PAGE_W-1:0]    page_out_q;
	logic [STAT_W-1:0]    status_q;
	logic [CNT_OUT_W-1:0] entry_count_q;

	logic in_fire, apply_go, apply_fire, cfg_wr;

	logic [KEY_BITS-1:0] key_arr  [ENTRIES];
	logic [PAGE_W-1:0]   page_arr [ENTRIES];
	cell_flags_t         flags_arr [ENTRIES];
	cell_op_t            cell_op  [ENTRIES];

	logic [ENTRIES-1:0] occ, occ_up, at_cnt, last_hot;
	logic [ENTRIES-1:0] eqk_v, ge_v, eqp_v;
	logic [ENTRIES-1:0] incl_eqk, incl_ge, incl_eqp;
	logic [ENTRIES-1:0] first_eqk, first_ge, first_eqp, excl_ge, sel_hot;
	logic any_eqk, any_ge, any_eqp, last_ge, is_full, ins_ok, rem_ok;

	logic                 res_found;
	logic [PAGE_W-1:0]    res_page;
	logic [PAGE_W-1:0]    page_sel;
	logic [STAT_W-1:0]    res_status;
	logic [CNT_OUT_W-1:0] cnt_out;

	// handshakes
	assign apply_go   = !out_valid_q || rsp.ready;
	assign apply_fire = (state_q == ST_APPLY) && apply_go;
	assign req.ready  = (state_q == ST_IDLE) || apply_fire;
	assign in_fire    = req.valid && req.ready;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_KEY_SIGNED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_signed_q <= 1'b1;
		end else if (cfg_wr) begin
			key_signed_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[APB_ADDR_W-1] == REG_KEY_SIGNED) begin
			prdata[0] = key_signed_q;
		end
	end

	// key field to stored key width
	if (KEY_BITS > KEY_IN_W) begin : g_key_wide
		assign key_ext = {{(KEY_BITS-KEY_IN_W){1'b0}}, req.key};
	end else begin : g_key_narrow
		assign key_ext = req.key[KEY_BITS-1:0];
	end

	// request register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= req.kind;
			key_q  <= key_ext;
			page_q <= req.page;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (apply_go) state_q <= in_fire ? ST_CMP : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// cell row
	for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
		logic [KEY_BITS-1:0] lo_key, hi_key;
		logic [PAGE_W-1:0]   lo_page, hi_page;

		assign occ[j]      = count_q > CW'(j);
		assign at_cnt[j]   = count_q == CW'(j);
		assign last_hot[j] = count_q == CW'(j + 1);
		assign eqk_v[j]    = flags_arr[j].eq_key;
		assign ge_v[j]     = flags_arr[j].ge_key;
		assign eqp_v[j]    = flags_arr[j].eq_page;

		if (j == 0) begin : g_lo_edge
			assign lo_key  = '0;
			assign lo_page = '0;
		end else begin : g_lo
			assign lo_key  = key_arr[j-1];
			assign lo_page = page_arr[j-1];
		end

		if (j == ENTRIES - 1) begin : g_hi_edge
			assign hi_key  = '0;
			assign hi_page = '0;
		end else begin : g_hi
			assign hi_key  = key_arr[j+1];
			assign hi_page = page_arr[j+1];
		end

		// per-cell command for the apply cycle
		always_comb begin
			cell_op[j] = CELL_HOLD;
			if (apply_fire) begin
				case (kind_q)
					KIND_INSERT: begin
						if (ins_ok) begin
							if (first_ge[j] || (!any_ge && at_cnt[j])) begin
								cell_op[j] = CELL_LOAD;
							end else if (excl_ge[j] && (occ[j] || at_cnt[j])) begin
								cell_op[j] = CELL_SHIFT_UP;
							end
						end
					end
					KIND_REMOVE: begin
						if (rem_ok && incl_eqk[j] && occ_up[j]) cell_op[j] = CELL_SHIFT_DOWN;
					end
					KIND_UPDATE: begin
						if (eqk_v[j]) cell_op[j] = CELL_SET_PAGE;
					end
					KIND_REKEY: begin
						if (first_eqp[j]) cell_op[j] = CELL_SET_KEY;
					end
					default: begin
					end
				endcase
			end
		end

		skpn_cell #(
			.KW (KEY_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cap_en     (state_q == ST_CMP),
			.occ        (occ[j]),
			.key_signed (key_signed_q),
			.cmp_key    (key_q),
			.cmp_page   (page_q),
			.op         (cell_op[j]),
			.lo_key     (lo_key),
			.lo_page    (lo_page),
			.hi_key     (hi_key),
			.hi_page    (hi_page),
			.key        (key_arr[j]),
			.page       (page_arr[j]),
			.flags      (flags_arr[j])
		);
	end

	assign occ_up = occ >> 1;

	// first-hit selection over the row
	skpn_prefix #(.N(ENTRIES)) u_pfx_eqk (.a(eqk_v), .incl(incl_eqk));
	skpn_prefix #(.N(ENTRIES)) u_pfx_ge  (.a(ge_v),  .incl(incl_ge));
	skpn_prefix #(.N(ENTRIES)) u_pfx_eqp (.a(eqp_v), .incl(incl_eqp));

	assign excl_ge   = incl_ge << 1;
	assign first_eqk = eqk_v & ~(incl_eqk << 1);
	assign first_ge  = ge_v & ~excl_ge;
	assign first_eqp = eqp_v & ~(incl_eqp << 1);
	assign any_eqk   = incl_eqk[ENTRIES-1];
	assign any_ge    = incl_ge[ENTRIES-1];
	assign any_eqp   = incl_eqp[ENTRIES-1];
	// floor search misses when the query is above the last stored key
	assign last_ge   = |(ge_v & last_hot);

	assign is_full = count_q == CW'(ENTRIES);
	assign ins_ok  = (kind_q == KIND_INSERT) && !any_eqk && !is_full;
	assign rem_ok  = (kind_q == KIND_REMOVE) && any_eqk;

	// page of the selected entry
	assign sel_hot = (kind_q == KIND_FLOOR) ? first_ge : first_eqk;

	always_comb begin
		page_sel = '0;
		for (int j = 0; j < ENTRIES; j++) begin
			page_sel = page_sel | (page_arr[j] & {PAGE_W{sel_hot[j]}});
		end
	end

	// response fields
	always_comb begin
		res_found  = 1'b0;
		res_page   = '0;
		res_status = STAT_OK;
		case (kind_q)
			KIND_INSERT: begin
				if (any_eqk) res_status = STAT_DUP;
				else if (is_full) res_status = STAT_FULL;
			end
			KIND_REMOVE: begin
				if (!any_eqk) res_status = STAT_ABSENT;
			end
			KIND_FLOOR: begin
				res_found = last_ge;
				if (last_ge) res_page = page_sel;
				else res_status = STAT_ABSENT;
			end
			KIND_EXACT: begin
				res_found = any_eqk;
				if (any_eqk) res_page = page_sel;
				else res_status = STAT_ABSENT;
			end
			KIND_UPDATE: begin
				res_found = any_eqk;
				if (!any_eqk) res_status = STAT_ABSENT;
			end
			KIND_REKEY: begin
				if (!any_eqp) res_status = STAT_ABSENT;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cnt_next = count_q;
		if (ins_ok) cnt_next = count_q + CW'(1);
		else if (rem_ok) cnt_next = count_q - CW'(1);
	end

	if (CW >= CNT_OUT_W) begin : g_cnt_trunc
		assign cnt_out = cnt_next[CNT_OUT_W-1:0];
	end else begin : g_cnt_ext
		assign cnt_out = {{(CNT_OUT_W-CW){1'b0}}, cnt_next};
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (apply_fire) begin
			count_q <= cnt_next;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_fire) begin
			found_q       <= res_found;
			page_out_q    <= res_page;
			status_q      <= res_status;
			entry_count_q <= cnt_out;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = found_q;
	assign rsp.page_out    = page_out_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = entry_count_q;

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("entry count above node capacity");

	a_rsp_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_APPLY)
		else $error("response raised outside the apply cycle");

	a_first_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_APPLY |-> $onehot0(first_ge) && $onehot0(first_eqk)
			&& $onehot0(first_eqp))
		else $error("first-hit select is not one-hot");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		apply_fire && ins_ok |=> count_q == $past(count_q) + CW'(1))
		else $error("successful insert did not grow the node");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sorted key/page node
// Sends node requests over the valid/ready channels and checks every response against
// the hand-written answer of a typed corner row or else a copy of the node table that
// the bench keeps itself. A short table of corner requests runs first. Random traffic
// follows in six phases that vary idling on both channels and the key compare order.
// ----------------------------------------------------------------------------
module testbench;
	import skpn_pkg::*;

	localparam int ENTRIES      = 16;
	localparam int RESET_CYCLES = 12;
	localparam int QUIET_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 8;
	localparam int SETTLE       = 4;
	localparam int PHASE_ITEMS  = 225;
	localparam int NUM_PHASES   = 6;
	localparam int MAX_REPORTS  = 10;

	// kinds that the node ignores
	localparam logic [KIND_W-1:0] KIND_RSVD_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RSVD_B = 3'd7;

	localparam logic [PAGE_W-1:0]   PAGE_MAX = {PAGE_W{1'b1}};
	localparam logic [KEY_IN_W-1:0] KEY_SMIN = 32'h8000_0000;
	localparam logic [KEY_IN_W-1:0] KEY_SMAX = 32'h7FFF_FFFF;
	localparam logic [KEY_IN_W-1:0] KEY_UMAX = 32'hFFFF_FFFF;
	localparam logic [APB_ADDR_W-1:0] ADDR_KEY_SIGNED = APB_ADDR_W'(REG_KEY_SIGNED) << 2;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [KEY_IN_W-1:0] key;
		logic [PAGE_W-1:0]   page;
	} node_req_t;

	typedef struct packed {
		logic                 found;
		logic [PAGE_W-1:0]    page_out;
		logic [STAT_W-1:0]    status;
		logic [CNT_OUT_W-1:0] entry_count;
	} node_rsp_t;

	// one row of the corner table; typed rows carry a hand-written answer
	typedef struct packed {
		node_req_t rq;
		logic      typed;
		node_rsp_t want;
	} corner_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	skpn_req_if req_ch ();
	skpn_rsp_if rsp_ch ();

	sorted_key_pointer_node_top #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_IN_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// mirror of the node table
	logic [KEY_IN_W-1:0] node_key [ENTRIES];
	logic [PAGE_W-1:0]   node_page [ENTRIES];
	int                  node_count;
	bit                  node_signed;

	node_rsp_t   due_rsp [$];
	corner_row_t corner_rows [$];

	int tx_idle_pct;
	int rx_stall_pct;
	int n_errors;
	int n_sent;
	int n_checked;
	int n_found;
	int n_full;
	int n_dup;
	int n_absent;
	int quiet_cycles;

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic flag_error(input string what);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $time, what);
	endtask

	// ---------------------------------------------------------------- mirror

	function automatic bit key_above(logic [KEY_IN_W-1:0] a, logic [KEY_IN_W-1:0] b);
		if (node_signed)
			return $signed(a) > $signed(b);
		return a > b;
	endfunction

	function automatic int first_equal(logic [KEY_IN_W-1:0] k);
		int i;
		for (i = 0; i < node_count; i++)
			if (node_key[i] == k)
				break;
		return i;
	endfunction

	function automatic int first_not_below(logic [KEY_IN_W-1:0] k);
		int i;
		for (i = 0; i < node_count; i++)
			if (!key_above(k, node_key[i]))
				break;
		return i;
	endfunction

	// apply one request to the mirror and return the response it gives
	function automatic node_rsp_t node_apply(node_req_t rq);
		node_rsp_t o;
		int i;
		int j;
		o = '0;
		case (rq.kind)
			KIND_INSERT: begin
				if (first_equal(rq.key) < node_count) begin
					o.status = STAT_DUP;
				end else if (node_count >= ENTRIES) begin
					o.status = STAT_FULL;
				end else begin
					i = first_not_below(rq.key);
					for (j = node_count; j > i; j--) begin
						node_key[j]  = node_key[j-1];
						node_page[j] = node_page[j-1];
					end
					node_key[i]  = rq.key;
					node_page[i] = rq.page;
					node_count++;
				end
			end
			KIND_REMOVE: begin
				i = first_equal(rq.key);
				if (i >= node_count) begin
					o.status = STAT_ABSENT;
				end else begin
					for (j = i; j + 1 < node_count; j++) begin
						node_key[j]  = node_key[j+1];
						node_page[j] = node_page[j+1];
					end
					node_count--;
				end
			end
			KIND_FLOOR: begin
				if (node_count == 0 || key_above(rq.key, node_key[node_count-1])) begin
					o.status = STAT_ABSENT;
				end else begin
					i = first_not_below(rq.key);
					if (i < node_count) begin
						o.found    = 1'b1;
						o.page_out = node_page[i];
					end else begin
						o.status = STAT_ABSENT;
					end
				end
			end
			KIND_EXACT: begin
				i = first_equal(rq.key);
				if (i < node_count) begin
					o.found    = 1'b1;
					o.page_out = node_page[i];
				end else begin
					o.status = STAT_ABSENT;
				end
			end
			KIND_UPDATE: begin
				// every equal key gets the new page
				for (i = 0; i < node_count; i++) begin
					if (node_key[i] == rq.key) begin
						node_page[i] = rq.page;
						o.found      = 1'b1;
					end
				end
				if (!o.found)
					o.status = STAT_ABSENT;
			end
			KIND_REKEY: begin
				for (i = 0; i < node_count; i++)
					if (node_page[i] == rq.page)
						break;
				if (i < node_count)
					node_key[i] = rq.key;
				else
					o.status = STAT_ABSENT;
			end
			default: begin
			end
		endcase
		o.entry_count = CNT_OUT_W'(node_count);
		return o;
	endfunction

	// ------------------------------------------------------------- stimulus

	function automatic node_rsp_t answer(logic [STAT_W-1:0] st, int cnt);
		node_rsp_t o;
		o             = '0;
		o.status      = st;
		o.entry_count = CNT_OUT_W'(cnt);
		return o;
	endfunction

	function automatic void add_row(logic [KIND_W-1:0] kind, logic [KEY_IN_W-1:0] key,
			logic [PAGE_W-1:0] page, logic typed, node_rsp_t want);
		corner_row_t row;
		row.rq    = '{kind, key, page};
		row.typed = typed;
		row.want  = want;
		corner_rows.push_back(row);
	endfunction

	// corner table: empty node, extremes, filling to full, refusals
	function automatic void load_corner_rows();
		int i;
		add_row(KIND_FLOOR, '0, '0, 1'b1, answer(STAT_ABSENT, 0));
		add_row(KIND_EXACT, KEY_UMAX, '0, 1'b1, answer(STAT_ABSENT, 0));
		add_row(KIND_RSVD_A, KEY_UMAX, PAGE_MAX, 1'b1, answer(STAT_OK, 0));
		add_row(KIND_RSVD_B, '0, '0, 1'b1, answer(STAT_OK, 0));
		add_row(KIND_INSERT, KEY_SMIN, PAGE_MAX, 1'b1, answer(STAT_OK, 1));
		add_row(KIND_INSERT, KEY_SMAX, '0, 1'b1, answer(STAT_OK, 2));
		add_row(KIND_INSERT, '0, PAGE_W'(1), 1'b1, answer(STAT_OK, 3));
		// descending keys so every insert shifts the tail
		for (i = 1; i <= ENTRIES - 3; i++)
			add_row(KIND_INSERT, KEY_IN_W'(ENTRIES - 2 - i) * 32'h0900_0000 + 32'h10,
				PAGE_W'(i + 1), 1'b0, '0);
		add_row(KIND_INSERT, 32'h5555_5555, PAGE_W'(77), 1'b1, answer(STAT_FULL, ENTRIES));
		add_row(KIND_INSERT, KEY_SMIN, '0, 1'b1, answer(STAT_DUP, ENTRIES));
		add_row(KIND_FLOOR, KEY_UMAX, '0, 1'b0, '0);
		add_row(KIND_UPDATE, KEY_SMAX, 31'h2AAA_AAAA, 1'b0, '0);
		add_row(KIND_REKEY, KEY_SMAX, PAGE_MAX, 1'b0, '0);
		add_row(KIND_REMOVE, '0, '0, 1'b0, '0);
	endfunction

	function automatic logic [KEY_IN_W-1:0] pick_key();
		int r;
		logic [KEY_IN_W-1:0] k;
		r = $urandom_range(0, 99);
		if (node_count > 0 && r < 45) begin
			k = node_key[$urandom_range(0, node_count - 1)];
			if (r >= 33)
				k = k + $urandom_range(0, 2) - 1;
		end else if (r < 65) begin
			case ($urandom_range(0, 6))
				0: k = '0;
				1: k = 32'd1;
				2: k = KEY_SMAX;
				3: k = KEY_SMIN;
				4: k = KEY_UMAX;
				5: k = KEY_SMAX - 1;
				default: k = KEY_SMIN + 1;
			endcase
		end else begin
			k = $urandom;
		end
		return k;
	endfunction

	function automatic logic [PAGE_W-1:0] pick_page();
		int r;
		r = $urandom_range(0, 99);
		if (node_count > 0 && r < 30)
			return node_page[$urandom_range(0, node_count - 1)];
		if (r < 36)
			return '0;
		if (r < 42)
			return PAGE_MAX;
		return PAGE_W'($urandom);
	endfunction

	// draining leans on remove so the node empties now and then
	function automatic node_req_t make_random_request(bit draining);
		node_req_t rq;
		int r;
		r = $urandom_range(0, 99);
		if (r < (draining ? 15 : 45))
			rq.kind = KIND_INSERT;
		else if (r < 55)
			rq.kind = KIND_REMOVE;
		else if (r < 70)
			rq.kind = KIND_FLOOR;
		else if (r < 80)
			rq.kind = KIND_EXACT;
		else if (r < 88)
			rq.kind = KIND_UPDATE;
		else if (r < 96)
			rq.kind = KIND_REKEY;
		else
			rq.kind = r[0] ? KIND_RSVD_A : KIND_RSVD_B;
		rq.key  = pick_key();
		rq.page = pick_page();
		return rq;
	endfunction

	// drive one request; valid stays high into the next call unless it idles
	task automatic send_request(input node_req_t rq, input logic typed, input node_rsp_t want);
		node_rsp_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind  <= rq.kind;
		req_ch.key   <= rq.key;
		req_ch.page  <= rq.page;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		predicted = node_apply(rq);
		due_rsp.push_back(typed ? want : predicted);
		n_sent++;
	endtask

	// stop sending and wait for every outstanding response
	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (due_rsp.size() != 0)
			@(posedge clk);
	endtask

	// write key_signed while idle, then read it back
	task automatic set_key_order(input bit signed_keys);
		logic [APB_DATA_W-1:0] rd;
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ADDR_KEY_SIGNED;
		pwdata  <= APB_DATA_W'(signed_keys);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		node_signed = signed_keys;
		if (rd !== APB_DATA_W'(signed_keys))
			flag_error($sformatf("key_signed read back %h, wrote %0d", rd, signed_keys));
	endtask

	// ------------------------------------------------------------- checking

	// response sink stalls at random
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin : rsp_check
		node_rsp_t got;
		node_rsp_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got.found       = rsp_ch.found;
			got.page_out    = rsp_ch.page_out;
			got.status      = rsp_ch.status;
			got.entry_count = rsp_ch.entry_count;
			if (due_rsp.size() == 0) begin
				flag_error($sformatf("response with none outstanding: found %b page %h st %0d cnt %0d",
					got.found, got.page_out, got.status, got.entry_count));
			end else begin
				want = due_rsp.pop_front();
				n_checked++;
				n_found  += want.found;
				n_full   += (want.status == STAT_FULL);
				n_dup    += (want.status == STAT_DUP);
				n_absent += (want.status == STAT_ABSENT);
				if (got.found !== want.found || got.page_out !== want.page_out
						|| got.status !== want.status || got.entry_count !== want.entry_count)
					flag_error($sformatf(
						"response %0d: exp found %b page %h st %0d cnt %0d, got %b %h %0d %0d",
						n_checked, want.found, want.page_out, want.status, want.entry_count,
						got.found, got.page_out, got.status, got.entry_count));
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
				quiet_cycles, due_rsp.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------- sequence

	initial begin : run
		bit phase_signed [NUM_PHASES];
		node_req_t rq;
		int ph;
		int counted;
		phase_signed = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		req_ch.valid = 1'b0;
		req_ch.kind  = '0;
		req_ch.key   = '0;
		req_ch.page  = '0;
		rsp_ch.ready = 1'b0;
		node_count   = 0;
		node_signed  = 1'b1;
		tx_idle_pct  = 10;
		rx_stall_pct = 64;
		n_errors     = 0;
		n_sent       = 0;
		n_checked    = 0;
		n_found      = 0;
		n_full       = 0;
		n_dup        = 0;
		n_absent     = 0;
		quiet_cycles = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// corner table under the reset compare order
		load_corner_rows();
		foreach (corner_rows[i])
			send_request(corner_rows[i].rq, corner_rows[i].typed, corner_rows[i].want);

		// random phases: sender idles / receiver stalls, swapped, then none
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			tx_idle_pct  = (ph < 2) ? 10 : (ph < 4) ? 64 : 0;
			rx_stall_pct = (ph < 2) ? 64 : (ph < 4) ? 10 : 0;
			set_key_order(phase_signed[ph]);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) == 0)
					wait_drained();
				rq = make_random_request(((counted / 48) % 2) == 1);
				send_request(rq, 1'b0, '0);
				if (rq.kind <= KIND_REKEY)
					counted++;
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		n_errors += due_rsp.size();
		$display("covered %0d requests in %0d phases, both key orders; %0d responses checked",
			n_sent, NUM_PHASES, n_checked);
		$display("hits %0d, node full %0d, duplicate %0d, key absent %0d, errors %0d",
			n_found, n_full, n_dup, n_absent, n_errors);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
